// ----- hw/rtl/v4a_pkg.sv -----
package v4a_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned KIND_BITS     = 4;

  typedef enum logic [KIND_BITS-1:0] {
    OP_NEG   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_SADD  = 4'd5,
    OP_SSUB  = 4'd6,
    OP_SMUL  = 4'd7,
    OP_SDIV  = 4'd8,
    OP_LEN   = 4'd9,
    OP_NORM  = 4'd10,
    OP_DIR   = 4'd11,
    OP_DIST  = 4'd12,
    OP_DOT   = 4'd13,
    OP_CROSS = 4'd14
  } op_e;

  // opcode plus clip status, carried along the pipeline
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic                 clip;
  } ctl_t;

  localparam int unsigned CTL_BITS = $bits(ctl_t);

endpackage

// ----- hw/rtl/vec4_vector_alu_core.sv -----
// Four-component signed fixed-point vector ALU (Q16.16 at default settings).
// Each input beat carries vectors a and b, a scalar and an opcode (in tuser);
// each result beat carries a vector, a scalar and the div_fault / saturated
// flags (in tuser). One beat enters per clock while the output is not held
// off. Every item, of any opcode, goes through the same stages from accept
// to result: four front stages (operand select, multiply, combine, scale
// and saturate), WORD_BITS+2 square-root stages that each settle one root
// bit, WORD_BITS+FRAC_BITS+1 divider stages that each settle one quotient
// bit, and the output register. When the output is held off the whole
// pipeline freezes in place, so s_axis_tready_o follows m_axis_tready_i
// combinationally while a result is waiting.
module vec4_vector_alu_core #(
  parameter int unsigned FRAC_BITS = v4a_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = v4a_pkg::WORD_BITS_DEF,
  localparam int unsigned IN_BITS  = ((9 * WORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ((5 * WORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in
  input  logic [IN_BITS-1:0]            s_axis_tdata_i,
  // kind
  input  logic [v4a_pkg::KIND_BITS-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // r_x, r_y, r_z, r_w, r_scalar
  output logic [OUT_BITS-1:0]           m_axis_tdata_o,
  // div_fault, saturated
  output logic [1:0]                    m_axis_tuser_o
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned WE  = W + 1;             // b - a stays exact
  localparam int unsigned SB  = 2 * WE + 2;        // sum of four squares
  localparam int unsigned RT  = SB / 2;            // root width
  localparam int unsigned NB  = WE + F;            // dividend / quotient width
  localparam int unsigned QSB = NB + 1;            // signed quotient
  localparam int unsigned PW1 = v4a_pkg::CTL_BITS + 5 * W + 4 * WE + 4 * W;
  localparam int unsigned PW2 = v4a_pkg::CTL_BITS + 5 * W + RT + 16;

  // {clip, value}
  function automatic logic [W:0] sat_q(input logic signed [QSB-1:0] x);
    logic fits;
    fits = (x[QSB-1:W-1] == {(QSB-W+1){1'b0}}) || (x[QSB-1:W-1] == {(QSB-W+1){1'b1}});
    if (fits) begin
      sat_q = {1'b0, x[W-1:0]};
    end else if (x[QSB-1]) begin
      sat_q = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      sat_q = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // global advance: everything moves when the output slot is free or taken
  logic adv;
  logic out_vld_q;
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---- front: products, sums, linear ops, pre-saturated results
  logic               f_vld;
  v4a_pkg::ctl_t      f_ctl;
  logic [3:0][W-1:0]  f_r;
  logic [W-1:0]       f_rs;
  logic [SB-1:0]      f_rad;
  logic [3:0][WE-1:0] f_num;
  logic [3:0][W-1:0]  f_den;

  v4a_front #(.W(W), .F(F)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_axis_tvalid_i),
    .kind_i (s_axis_tuser_i),
    .a_i    (s_axis_tdata_i[4*W-1:0]),
    .b_i    (s_axis_tdata_i[8*W-1:4*W]),
    .s_i    (s_axis_tdata_i[9*W-1:8*W]),
    .vld_o  (f_vld),
    .ctl_o  (f_ctl),
    .r_o    (f_r),
    .rs_o   (f_rs),
    .rad_o  (f_rad),
    .num_o  (f_num),
    .den_o  (f_den)
  );

  // ---- square root of the sum of squares; the rest of the item rides along
  logic               q_vld;
  logic [RT-1:0]      q_root;
  logic [PW1-1:0]     q_side;
  v4a_pkg::ctl_t      q_ctl;
  logic [3:0][W-1:0]  q_r;
  logic [W-1:0]       q_rs;
  logic [3:0][WE-1:0] q_num;
  logic [3:0][W-1:0]  q_den;

  v4a_sqrt #(.RW(SB), .PW(PW1)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (f_vld),
    .rad_i  (f_rad),
    .side_i ({f_ctl, f_r, f_rs, f_num, f_den}),
    .vld_o  (q_vld),
    .root_o (q_root),
    .side_o (q_side)
  );

  assign {q_ctl, q_r, q_rs, q_num, q_den} = q_side;

  // ---- divider operands: element / scalar divide, or component / length
  logic               is_norm;
  logic [WE-1:0]      nmag [4];
  logic [W-1:0]       dmag [4];
  logic [3:0][NB-1:0] dvd;
  logic [3:0][RT-1:0] dvs;
  logic [3:0]         neg;
  logic [3:0]         numz;
  logic [3:0]         numneg;
  logic [3:0]         dz;

  always_comb begin
    is_norm = (q_ctl.kind == v4a_pkg::OP_NORM) || (q_ctl.kind == v4a_pkg::OP_DIR);
    for (int i = 0; i < 4; i++) begin
      numneg[i] = q_num[i][WE-1];
      numz[i]   = (q_num[i] == '0);
      nmag[i]   = numneg[i] ? (-q_num[i]) : q_num[i];
      dmag[i]   = q_den[i][W-1] ? (-q_den[i]) : q_den[i];
      dvd[i]    = {nmag[i], {F{1'b0}}};
      dvs[i]    = is_norm ? q_root : RT'(dmag[i]);
      neg[i]    = numneg[i] ^ (!is_norm && q_den[i][W-1]);
      dz[i]     = (dvs[i] == '0);
    end
  end

  // ---- divider
  logic               d_vld;
  logic [3:0][NB-1:0] d_quo;
  logic [PW2-1:0]     d_side;
  v4a_pkg::ctl_t      d_ctl;
  logic [3:0][W-1:0]  d_r;
  logic [W-1:0]       d_rs;
  logic [RT-1:0]      d_root;
  logic [3:0]         d_neg;
  logic [3:0]         d_numz;
  logic [3:0]         d_numneg;
  logic [3:0]         d_dz;

  v4a_div #(.NB(NB), .DB(RT), .PW(PW2)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (q_vld),
    .dvd_i  (dvd),
    .dvs_i  (dvs),
    .side_i ({q_ctl, q_r, q_rs, q_root, neg, numz, numneg, dz}),
    .vld_o  (d_vld),
    .quo_o  (d_quo),
    .side_o (d_side)
  );

  assign {d_ctl, d_r, d_rs, d_root, d_neg, d_numz, d_numneg, d_dz} = d_side;

  // ---- final select: quotients, length, divide-by-zero handling
  logic [QSB-1:0]    qs [4];
  logic [W:0]        qv [4];
  logic [W:0]        lv;
  logic [3:0][W-1:0] fin_r;
  logic [W-1:0]      fin_rs;
  logic              fin_clip;
  logic              fin_fault;

  always_comb begin
    fin_r     = d_r;
    fin_rs    = d_rs;
    fin_clip  = d_ctl.clip;
    fin_fault = 1'b0;
    lv        = sat_q(QSB'(d_root));
    for (int i = 0; i < 4; i++) begin
      qs[i] = {1'b0, d_quo[i]};
      if (d_neg[i]) qs[i] = -qs[i];
      qv[i] = sat_q(qs[i]);
    end
    case (d_ctl.kind)
      v4a_pkg::OP_DIV, v4a_pkg::OP_SDIV: begin
        for (int i = 0; i < 4; i++) begin
          if (d_dz[i]) begin
            // divide by zero: signed full scale, zero over zero stays zero
            fin_fault = 1'b1;
            if (d_numz[i]) begin
              fin_r[i] = '0;
            end else if (d_numneg[i]) begin
              fin_r[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
              fin_r[i] = {1'b0, {(W-1){1'b1}}};
            end
          end else begin
            fin_r[i] = qv[i][W-1:0];
            fin_clip = fin_clip | qv[i][W];
          end
        end
      end
      v4a_pkg::OP_NORM, v4a_pkg::OP_DIR: begin
        if (d_dz[0]) begin
          // zero-length vector: flag it, return the zero vector
          fin_fault = 1'b1;
          fin_r     = '0;
        end else begin
          for (int i = 0; i < 4; i++) begin
            fin_r[i] = qv[i][W-1:0];
            fin_clip = fin_clip | qv[i][W];
          end
        end
      end
      v4a_pkg::OP_LEN, v4a_pkg::OP_DIST: begin
        fin_rs   = lv[W-1:0];
        fin_clip = fin_clip | lv[W];
      end
      default: begin
      end
    endcase
  end

  // ---- output register
  logic [3:0][W-1:0] out_r_q;
  logic [W-1:0]      out_rs_q;
  logic              out_fault_q;
  logic              out_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_r_q     <= fin_r;
      out_rs_q    <= fin_rs;
      out_fault_q <= fin_fault;
      out_clip_q  <= fin_clip;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_BITS'({out_rs_q, out_r_q});
  assign m_axis_tuser_o  = {out_clip_q, out_fault_q};

  // ---- checks
  // faults only come from divide and normalize, which leave the scalar at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_fault_q) |-> (out_rs_q == '0))
    else $error("div_fault raised on a beat with a scalar result");

  // scalar results (length, distance, dot) come with a zero vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_rs_q != '0)) |-> (out_r_q == '0))
    else $error("scalar result beat carries a nonzero vector");

endmodule

// ----- hw/rtl/v4a_front.sv -----
module v4a_front #(
  parameter int unsigned W = v4a_pkg::WORD_BITS_DEF,
  parameter int unsigned F = v4a_pkg::FRAC_BITS_DEF,
  localparam int unsigned WE = W + 1,
  localparam int unsigned PB = 2 * WE,
  localparam int unsigned SB = PB + 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            vld_i,
  input  logic [v4a_pkg::KIND_BITS-1:0]   kind_i,
  input  logic [3:0][W-1:0]               a_i,
  input  logic [3:0][W-1:0]               b_i,
  input  logic [W-1:0]                    s_i,
  output logic                            vld_o,
  output v4a_pkg::ctl_t                   ctl_o,
  output logic [3:0][W-1:0]               r_o,
  output logic [W-1:0]                    rs_o,
  output logic [SB-1:0]                   rad_o,
  output logic [3:0][WE-1:0]              num_o,
  output logic [3:0][W-1:0]               den_o
);

  // {clip, value}
  function automatic logic [W:0] sat_w(input logic signed [SB-1:0] x);
    logic fits;
    fits = (x[SB-1:W-1] == {(SB-W+1){1'b0}}) || (x[SB-1:W-1] == {(SB-W+1){1'b1}});
    if (fits) begin
      sat_w = {1'b0, x[W-1:0]};
    end else if (x[SB-1]) begin
      sat_w = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      sat_w = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // stage 1: operand select
  logic signed [WE-1:0] ae [4];
  logic signed [WE-1:0] be [4];
  logic signed [WE-1:0] de [4];
  logic signed [WE-1:0] se;
  logic signed [WE-1:0] pa_d [8];
  logic signed [WE-1:0] pb_d [8];
  logic [3:0][WE-1:0]   num_d;
  logic [3:0][W-1:0]    den_d;

  logic                          vld1_q;
  logic [v4a_pkg::KIND_BITS-1:0] kind1_q;
  logic signed [WE-1:0]          ae1_q [4];
  logic signed [WE-1:0]          be1_q [4];
  logic signed [WE-1:0]          se1_q;
  logic signed [WE-1:0]          pa1_q [8];
  logic signed [WE-1:0]          pb1_q [8];
  logic [3:0][WE-1:0]            num1_q;
  logic [3:0][W-1:0]             den1_q;

  always_comb begin
    se = {s_i[W-1], s_i};
    for (int i = 0; i < 4; i++) begin
      ae[i]    = {a_i[i][W-1], a_i[i]};
      be[i]    = {b_i[i][W-1], b_i[i]};
      de[i]    = be[i] - ae[i];
      num_d[i] = (kind_i == v4a_pkg::OP_DIR) ? de[i] : ae[i];
      den_d[i] = (kind_i == v4a_pkg::OP_SDIV) ? s_i : b_i[i];
    end
    for (int j = 0; j < 8; j++) begin
      pa_d[j] = '0;
      pb_d[j] = '0;
    end
    case (kind_i)
      v4a_pkg::OP_MUL, v4a_pkg::OP_DOT: begin
        for (int i = 0; i < 4; i++) begin
          pa_d[i] = ae[i];
          pb_d[i] = be[i];
        end
      end
      v4a_pkg::OP_SMUL: begin
        for (int i = 0; i < 4; i++) begin
          pa_d[i] = ae[i];
          pb_d[i] = se;
        end
      end
      v4a_pkg::OP_LEN, v4a_pkg::OP_NORM: begin
        for (int i = 0; i < 4; i++) begin
          pa_d[i] = ae[i];
          pb_d[i] = ae[i];
        end
      end
      v4a_pkg::OP_DIR, v4a_pkg::OP_DIST: begin
        for (int i = 0; i < 4; i++) begin
          pa_d[i] = de[i];
          pb_d[i] = de[i];
        end
      end
      v4a_pkg::OP_CROSS: begin
        pa_d[0] = ae[1]; pb_d[0] = be[2];
        pa_d[1] = ae[2]; pb_d[1] = be[1];
        pa_d[2] = ae[2]; pb_d[2] = be[0];
        pa_d[3] = ae[0]; pb_d[3] = be[2];
        pa_d[4] = ae[0]; pb_d[4] = be[1];
        pa_d[5] = ae[1]; pb_d[5] = be[0];
      end
      default: begin
      end
    endcase
  end

  // stage 2: products and linear ops
  logic signed [PB-1:0] prod_d [8];
  logic signed [WE-1:0] lin_d [4];

  logic                          vld2_q;
  logic [v4a_pkg::KIND_BITS-1:0] kind2_q;
  logic signed [PB-1:0]          prod2_q [8];
  logic signed [WE-1:0]          lin2_q [4];
  logic [3:0][WE-1:0]            num2_q;
  logic [3:0][W-1:0]             den2_q;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      prod_d[j] = pa1_q[j] * pb1_q[j];
    end
    for (int i = 0; i < 4; i++) begin
      case (kind1_q)
        v4a_pkg::OP_NEG:  lin_d[i] = -ae1_q[i];
        v4a_pkg::OP_ADD:  lin_d[i] = ae1_q[i] + be1_q[i];
        v4a_pkg::OP_SUB:  lin_d[i] = ae1_q[i] - be1_q[i];
        v4a_pkg::OP_SADD: lin_d[i] = ae1_q[i] + se1_q;
        v4a_pkg::OP_SSUB: lin_d[i] = ae1_q[i] - se1_q;
        default:          lin_d[i] = '0;
      endcase
    end
  end

  // stage 3: combine products
  logic signed [SB-1:0] pe [8];
  logic signed [SB-1:0] cv_d [4];
  logic signed [SB-1:0] sc_d;

  logic                          vld3_q;
  logic [v4a_pkg::KIND_BITS-1:0] kind3_q;
  logic signed [SB-1:0]          cv3_q [4];
  logic signed [SB-1:0]          sc3_q;
  logic signed [WE-1:0]          lin3_q [4];
  logic [3:0][WE-1:0]            num3_q;
  logic [3:0][W-1:0]             den3_q;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pe[j] = {{2{prod2_q[j][PB-1]}}, prod2_q[j]};
    end
    for (int i = 0; i < 4; i++) begin
      cv_d[i] = pe[i];
    end
    if (kind2_q == v4a_pkg::OP_CROSS) begin
      cv_d[0] = pe[0] - pe[1];
      cv_d[1] = pe[2] - pe[3];
      cv_d[2] = pe[4] - pe[5];
      cv_d[3] = '0;
    end
    sc_d = pe[0] + pe[1] + pe[2] + pe[3];
  end

  // stage 4: scale and saturate
  logic signed [SB-1:0] shv [4];
  logic signed [SB-1:0] lxv [4];
  logic signed [SB-1:0] scs;
  logic [W:0]           sm [4];
  logic [W:0]           sl [4];
  logic [W:0]           ss;
  logic [3:0][W-1:0]    r_d;
  logic [W-1:0]         rs_d;
  logic                 clip_d;

  logic                          vld4_q;
  logic [v4a_pkg::KIND_BITS-1:0] kind4_q;
  logic                          clip4_q;
  logic [3:0][W-1:0]             r4_q;
  logic [W-1:0]                  rs4_q;
  logic [SB-1:0]                 rad4_q;
  logic [3:0][WE-1:0]            num4_q;
  logic [3:0][W-1:0]             den4_q;

  always_comb begin
    clip_d = 1'b0;
    scs    = sc3_q >>> F;
    ss     = sat_w(scs);
    rs_d   = '0;
    for (int i = 0; i < 4; i++) begin
      shv[i] = cv3_q[i] >>> F;
      lxv[i] = {{(SB-WE){lin3_q[i][WE-1]}}, lin3_q[i]};
      sm[i]  = sat_w(shv[i]);
      sl[i]  = sat_w(lxv[i]);
      r_d[i] = '0;
      case (kind3_q)
        v4a_pkg::OP_MUL, v4a_pkg::OP_SMUL, v4a_pkg::OP_CROSS: begin
          r_d[i] = sm[i][W-1:0];
          clip_d = clip_d | sm[i][W];
        end
        v4a_pkg::OP_NEG, v4a_pkg::OP_ADD, v4a_pkg::OP_SUB,
        v4a_pkg::OP_SADD, v4a_pkg::OP_SSUB: begin
          r_d[i] = sl[i][W-1:0];
          clip_d = clip_d | sl[i][W];
        end
        default: begin
        end
      endcase
    end
    if (kind3_q == v4a_pkg::OP_DOT) begin
      rs_d   = ss[W-1:0];
      clip_d = ss[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind1_q <= kind_i;
      se1_q   <= se;
      num1_q  <= num_d;
      den1_q  <= den_d;
      for (int i = 0; i < 4; i++) begin
        ae1_q[i] <= ae[i];
        be1_q[i] <= be[i];
      end
      for (int j = 0; j < 8; j++) begin
        pa1_q[j]   <= pa_d[j];
        pb1_q[j]   <= pb_d[j];
        prod2_q[j] <= prod_d[j];
      end
      kind2_q <= kind1_q;
      num2_q  <= num1_q;
      den2_q  <= den1_q;
      kind3_q <= kind2_q;
      num3_q  <= num2_q;
      den3_q  <= den2_q;
      sc3_q   <= sc_d;
      for (int i = 0; i < 4; i++) begin
        lin2_q[i] <= lin_d[i];
        lin3_q[i] <= lin2_q[i];
        cv3_q[i]  <= cv_d[i];
      end
      kind4_q <= kind3_q;
      clip4_q <= clip_d;
      r4_q    <= r_d;
      rs4_q   <= rs_d;
      rad4_q  <= sc3_q;
      num4_q  <= num3_q;
      den4_q  <= den3_q;
    end
  end

  assign vld_o      = vld4_q;
  assign ctl_o.kind = kind4_q;
  assign ctl_o.clip = clip4_q;
  assign r_o        = r4_q;
  assign rs_o       = rs4_q;
  assign rad_o      = rad4_q;
  assign num_o      = num4_q;
  assign den_o      = den4_q;

endmodule

// ----- hw/rtl/v4a_sqrt.sv -----
module v4a_sqrt #(
  parameter int unsigned RW = 68,
  parameter int unsigned PW = 8,
  localparam int unsigned RT = RW / 2,
  localparam int unsigned REMW = RT + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          vld_i,
  input  logic [RW-1:0] rad_i,
  input  logic [PW-1:0] side_i,
  output logic          vld_o,
  output logic [RT-1:0] root_o,
  output logic [PW-1:0] side_o
);

  // one root bit per stage, two radicand bits consumed per stage
  logic [RW-1:0]   acc_q  [RT];
  logic [REMW-1:0] rem_q  [RT];
  logic [RT-1:0]   root_q [RT];
  logic [PW-1:0]   side_q [RT];
  logic            vld_q  [RT];

  logic [RW-1:0]   acc_in  [RT];
  logic [REMW-1:0] rem_in  [RT];
  logic [RT-1:0]   root_in [RT];
  logic [PW-1:0]   side_in [RT];
  logic            vld_in  [RT];
  logic [REMW+1:0] rem_n   [RT];
  logic [REMW+1:0] trial   [RT];
  logic [REMW-1:0] rem_nx  [RT];
  logic [RT-1:0]   root_nx [RT];

  always_comb begin
    acc_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    side_in[0] = side_i;
    vld_in[0]  = vld_i;
    for (int k = 1; k < RT; k++) begin
      acc_in[k]  = acc_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      side_in[k] = side_q[k-1];
      vld_in[k]  = vld_q[k-1];
    end
    for (int k = 0; k < RT; k++) begin
      rem_n[k] = {rem_in[k], acc_in[k][RW-1 -: 2]};
      trial[k] = (REMW+2)'({root_in[k], 2'b01});
      if (rem_n[k] >= trial[k]) begin
        rem_nx[k]  = REMW'(rem_n[k] - trial[k]);
        root_nx[k] = {root_in[k][RT-2:0], 1'b1};
      end else begin
        rem_nx[k]  = REMW'(rem_n[k]);
        root_nx[k] = {root_in[k][RT-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RT; k++) vld_q[k] <= 1'b0;
    end else if (adv_i) begin
      for (int k = 0; k < RT; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < RT; k++) begin
        acc_q[k]  <= acc_in[k] << 2;
        rem_q[k]  <= rem_nx[k];
        root_q[k] <= root_nx[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign vld_o  = vld_q[RT-1];
  assign root_o = root_q[RT-1];
  assign side_o = side_q[RT-1];

endmodule

// ----- hw/rtl/v4a_div.sv -----
module v4a_div #(
  parameter int unsigned NB = 49,
  parameter int unsigned DB = 34,
  parameter int unsigned PW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                vld_i,
  input  logic [3:0][NB-1:0]  dvd_i,
  input  logic [3:0][DB-1:0]  dvs_i,
  input  logic [PW-1:0]       side_i,
  output logic                vld_o,
  output logic [3:0][NB-1:0]  quo_o,
  output logic [PW-1:0]       side_o
);

  // restoring divide, four lanes, one quotient bit per stage;
  // the dividend shifts out of nq as quotient bits shift in
  logic [3:0][NB-1:0] nq_q   [NB];
  logic [3:0][DB-1:0] rem_q  [NB];
  logic [3:0][DB-1:0] dvs_q  [NB];
  logic [PW-1:0]      side_q [NB];
  logic               vld_q  [NB];

  logic [3:0][NB-1:0] nq_in   [NB];
  logic [3:0][DB-1:0] rem_in  [NB];
  logic [3:0][DB-1:0] dvs_in  [NB];
  logic [PW-1:0]      side_in [NB];
  logic               vld_in  [NB];
  logic [DB:0]        rem_n   [NB][4];
  logic               take    [NB][4];
  logic [3:0][NB-1:0] nq_nx   [NB];
  logic [3:0][DB-1:0] rem_nx  [NB];

  always_comb begin
    nq_in[0]   = dvd_i;
    rem_in[0]  = '0;
    dvs_in[0]  = dvs_i;
    side_in[0] = side_i;
    vld_in[0]  = vld_i;
    for (int k = 1; k < NB; k++) begin
      nq_in[k]   = nq_q[k-1];
      rem_in[k]  = rem_q[k-1];
      dvs_in[k]  = dvs_q[k-1];
      side_in[k] = side_q[k-1];
      vld_in[k]  = vld_q[k-1];
    end
    for (int k = 0; k < NB; k++) begin
      for (int l = 0; l < 4; l++) begin
        rem_n[k][l] = {rem_in[k][l], nq_in[k][l][NB-1]};
        take[k][l]  = rem_n[k][l] >= {1'b0, dvs_in[k][l]};
        if (take[k][l]) begin
          rem_nx[k][l] = DB'(rem_n[k][l] - {1'b0, dvs_in[k][l]});
        end else begin
          rem_nx[k][l] = DB'(rem_n[k][l]);
        end
        nq_nx[k][l] = {nq_in[k][l][NB-2:0], take[k][l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NB; k++) vld_q[k] <= 1'b0;
    end else if (adv_i) begin
      for (int k = 0; k < NB; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NB; k++) begin
        nq_q[k]   <= nq_nx[k];
        rem_q[k]  <= rem_nx[k];
        dvs_q[k]  <= dvs_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign vld_o  = vld_q[NB-1];
  assign quo_o  = nq_q[NB-1];
  assign side_o = side_q[NB-1];

endmodule
